// ===== src/otds_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordering table depth sort: shared types and codes
// Opcodes, result status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package otds_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FETCH  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_EMITTED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load;       // capture the input word
        logic    ins_wr;     // write head, link and record of a new entry
        logic    scan_rd;    // read head of the current scan bucket
        logic    scan_chk;   // act on the head just read during a scan
        logic    emit;       // retire the current node
        logic    clr_start;  // empty counters and arm the clearing pass
        logic    clr_step;   // clear one bucket
        logic    set_drain;  // a fetch opens the drain
        logic    resp;       // present a result word
        t_status resp_code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic ins_drop;   // draining or pool full
        logic tbl_empty;  // everything already emitted
        logic node_vld;   // a node of the current bucket is pending
        logic scan_done;  // search went past bucket zero
        logic head_used;  // bucket read during a scan is occupied
        logic bkt_zero;   // scan bucket is the nearest one
        logic clr_last;   // clearing pass at its last bucket
    } t_stat;

endpackage

// ===== src/otds_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module otds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/otds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordering table controller
// Sequences insert, fetch scan and the clearing pass.
// ----------------------------------------------------------------------------
module otds_ctrl
    import otds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [7:0] {
        S_CLR      = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DEC      = 8'b0000_0100,
        S_INS_WR   = 8'b0000_1000,
        S_SCAN_RD  = 8'b0001_0000,
        S_SCAN_CHK = 8'b0010_0000,
        S_NODE_RD  = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.resp_code = ST_DROPPED;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.ins_drop) begin
                            o_cmd.resp = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_INS_WR;
                        end
                    end
                    OP_FETCH: begin
                        o_cmd.set_drain = 1'b1;
                        if (i_stat.tbl_empty || (!i_stat.node_vld && i_stat.scan_done)) begin
                            o_cmd.resp      = 1'b1;
                            o_cmd.resp_code = ST_EMPTY;
                            n_state         = S_IDLE;
                        end else if (i_stat.node_vld) begin
                            n_state = S_NODE_RD;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        o_cmd.resp      = 1'b1;
                        o_cmd.resp_code = ST_CLEARED;
                        n_state         = S_CLR;
                    end
                    default: begin
                        o_cmd.resp = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_INS_WR: begin
                o_cmd.ins_wr    = 1'b1;
                o_cmd.resp      = 1'b1;
                o_cmd.resp_code = ST_INSERTED;
                n_state         = S_IDLE;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_stat.head_used) begin
                    n_state = S_NODE_RD;
                end else if (i_stat.bkt_zero) begin
                    o_cmd.resp      = 1'b1;
                    o_cmd.resp_code = ST_EMPTY;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_NODE_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.resp      = 1'b1;
                o_cmd.resp_code = ST_EMITTED;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/otds_dp.sv =====
// ----------------------------------------------------------------------------
// Ordering table datapath
// Bucket head, link and record memories, pool and scan registers, result word.
// ----------------------------------------------------------------------------
module otds_dp
    import otds_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int POOL_SIZE   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_depth_key,
    input  logic [1:0]  i_prim_kind,
    input  logic [15:0] i_payload_tag,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_out_kind,
    output logic [15:0] o_out_tag,
    output logic [11:0] o_out_depth,
    output logic        o_last_of_frame
);

    localparam int BW = $clog2(TABLE_DEPTH);
    localparam int NW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    logic [1:0]    r_op;
    logic [BW-1:0] r_key;
    logic [1:0]    r_kind;
    logic [15:0]   r_tag;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_scan_bucket;
    logic [NW-1:0] r_scan_node;
    logic          r_node_vld;
    logic          r_scan_done;
    logic          r_drain;
    logic [BW-1:0] r_clr_addr;

    logic          r_valid;
    logic [2:0]    r_status;
    logic [1:0]    r_out_kind;
    logic [15:0]   r_out_tag;
    logic [11:0]   r_out_depth;
    logic          r_last;

    logic          key_clamp;
    logic [BW-1:0] key_bucket;
    logic          head_we;
    logic [BW-1:0] head_waddr;
    logic [NW:0]   head_wdata;
    logic [BW-1:0] head_raddr;
    logic [NW:0]   head_rdata;
    logic [NW:0]   link_wdata;
    logic [NW:0]   link_rdata;
    logic [17:0]   rec_rdata;
    logic [CW-1:0] count_inc;
    logic [31:0]   bucket_wide;

    assign key_clamp  = ({1'b0, i_depth_key} >= 17'(TABLE_DEPTH));
    assign key_bucket = key_clamp ? BW'(TABLE_DEPTH - 1) : i_depth_key[BW-1:0];

    // head word: {used, newest node}
    assign head_we    = i_cmd.ins_wr | i_cmd.clr_step;
    assign head_waddr = i_cmd.clr_step ? r_clr_addr : r_key;
    assign head_wdata = i_cmd.clr_step ? '0 : {1'b1, r_fill[NW-1:0]};
    assign head_raddr = i_cmd.scan_rd ? r_scan_bucket : r_key;

    // link word: {none, next older node}
    assign link_wdata = head_rdata[NW] ? {1'b0, head_rdata[NW-1:0]} : {1'b1, {NW{1'b0}}};

    otds_ram #(.WIDTH(NW + 1), .DEPTH(TABLE_DEPTH)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    otds_ram #(.WIDTH(NW + 1), .DEPTH(POOL_SIZE)) u_link (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr),
        .i_waddr (r_fill[NW-1:0]),
        .i_wdata (link_wdata),
        .i_raddr (r_scan_node),
        .o_rdata (link_rdata)
    );

    otds_ram #(.WIDTH(18), .DEPTH(POOL_SIZE)) u_rec (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr),
        .i_waddr (r_fill[NW-1:0]),
        .i_wdata ({r_kind, r_tag}),
        .i_raddr (r_scan_node),
        .o_rdata (rec_rdata)
    );

    assign count_inc   = r_count + CW'(1);
    assign bucket_wide = 32'(r_scan_bucket);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_key  <= key_bucket;
            r_kind <= i_prim_kind;
            r_tag  <= i_payload_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_count       <= '0;
            r_scan_bucket <= BW'(TABLE_DEPTH - 1);
            r_node_vld    <= 1'b0;
            r_scan_done   <= 1'b0;
            r_drain       <= 1'b0;
            r_clr_addr    <= BW'(TABLE_DEPTH - 1);
            r_valid       <= 1'b0;
        end else begin
            r_valid <= i_cmd.resp;
            if (i_cmd.clr_start) begin
                r_fill        <= '0;
                r_count       <= '0;
                r_scan_bucket <= BW'(TABLE_DEPTH - 1);
                r_node_vld    <= 1'b0;
                r_scan_done   <= 1'b0;
                r_drain       <= 1'b0;
                r_clr_addr    <= BW'(TABLE_DEPTH - 1);
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr - BW'(1);
            end
            if (i_cmd.set_drain) begin
                r_drain <= 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.scan_chk) begin
                if (head_rdata[NW]) begin
                    r_node_vld <= 1'b1;
                end else if (r_scan_bucket == '0) begin
                    r_scan_done <= 1'b1;
                end else begin
                    r_scan_bucket <= r_scan_bucket - BW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_count <= count_inc;
                if (link_rdata[NW]) begin
                    r_node_vld <= 1'b0;
                    if (r_scan_bucket == '0) begin
                        r_scan_done <= 1'b1;
                    end else begin
                        r_scan_bucket <= r_scan_bucket - BW'(1);
                    end
                end
            end
        end
    end

    // node pointer is payload: only meaningful while r_node_vld is set
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_chk && head_rdata[NW]) begin
            r_scan_node <= head_rdata[NW-1:0];
        end else if (i_cmd.emit && !link_rdata[NW]) begin
            r_scan_node <= link_rdata[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_status <= i_cmd.resp_code;
            if (i_cmd.emit) begin
                r_out_kind  <= rec_rdata[17:16];
                r_out_tag   <= rec_rdata[15:0];
                r_out_depth <= bucket_wide[11:0];
                r_last      <= (count_inc == r_fill);
            end else begin
                r_out_kind  <= '0;
                r_out_tag   <= '0;
                r_out_depth <= '0;
                r_last      <= 1'b0;
            end
        end
    end

    assign o_stat.op        = t_op'(r_op);
    assign o_stat.ins_drop  = r_drain || (r_fill >= CW'(POOL_SIZE));
    assign o_stat.tbl_empty = (r_count >= r_fill);
    assign o_stat.node_vld  = r_node_vld;
    assign o_stat.scan_done = r_scan_done;
    assign o_stat.head_used = head_rdata[NW];
    assign o_stat.bkt_zero  = (r_scan_bucket == '0);
    assign o_stat.clr_last  = (r_clr_addr == '0);

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_kind      = r_out_kind;
    assign o_out_tag       = r_out_tag;
    assign o_out_depth     = r_out_depth;
    assign o_last_of_frame = r_last;

endmodule

// ===== src/ordering_table_depth_sort_unit.sv =====
// ----------------------------------------------------------------------------
// Ordering table depth sort unit
// Painter's-order bucket table: insert, fetch farthest-first, clear.
// ----------------------------------------------------------------------------
// Issue a word by raising start while busy is low; every word answers with
// exactly one result, shown for one cycle under o_valid, and the receiver
// cannot stall it. An insert passes through decode and a write state; a
// dropped insert, an unused opcode and a fetch of an exhausted table answer
// from decode. A fetch that continues the current bucket reads the node and
// then emits it; otherwise the search first examines bucket heads, farthest
// first: the bucket heads sit in one registered RAM that is probed one bucket
// per read-and-check pair. A clear answers at once but keeps busy high while
// a clearing pass walks all TABLE_DEPTH buckets of the head RAM one bucket a
// cycle; the same pass runs after reset before the first word is taken.
// ----------------------------------------------------------------------------
module ordering_table_depth_sort_unit
    import otds_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int POOL_SIZE   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_depth_key,
    input  logic [1:0]  i_prim_kind,
    input  logic [15:0] i_payload_tag,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_out_kind,
    output logic [15:0] o_out_tag,
    output logic [11:0] o_out_depth,
    output logic        o_last_of_frame
);

    t_cmd  cmd;
    t_stat stat;

    // sequence each word through decode, memory access and result
    otds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // hold the table memories, the pool and scan pointers, and the result word
    otds_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POOL_SIZE   (POOL_SIZE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_depth_key     (i_depth_key),
        .i_prim_kind     (i_prim_kind),
        .i_payload_tag   (i_payload_tag),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_kind      (o_out_kind),
        .o_out_tag       (o_out_tag),
        .o_out_depth     (o_out_depth),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== dv/ordering_table_depth_sort_unit_test.sv =====
// ----------------------------------------------------------------------------
// Ordering table depth sort unit: self-checking testbench
// Drives insert, fetch and clear words in frames (clear, inserts, full drain),
// predicts every result word in a behavioral copy of the table and compares
// them field by field, under several phases of random start gaps.
// ----------------------------------------------------------------------------
module ordering_table_depth_sort_unit_test;
    import otds_pkg::*;

    localparam int NBKT        = 4096;
    localparam int NREC        = 4096;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        t_op         op;
        logic [15:0] key;
        logic [1:0]  kind;
        logic [15:0] tag;
    } t_word;

    typedef struct {
        t_status     status;
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [11:0] depth;
        logic        last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_depth_key = '0;
    logic [1:0]  i_prim_kind = '0;
    logic [15:0] i_payload_tag = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [1:0]  o_out_kind;
    logic [15:0] o_out_tag;
    logic [11:0] o_out_depth;
    logic        o_last_of_frame;

    t_word   word_q[$];     // words waiting to be issued
    t_answer answer_q[$];   // predicted result words, oldest first

    // behavioral copy of the table
    logic [11:0] tbl_head[NBKT];
    logic        tbl_used[NBKT];
    int          tbl_link[NREC];
    logic [17:0] tbl_rec[NREC];
    int          tbl_fill;
    int          tbl_emitted;
    int          tbl_scan_bkt;
    int          tbl_scan_node;
    logic        tbl_drain;

    int errors = 0;
    int cycles = 0;
    int words_taken = 0;
    int n_ins = 0, n_emit = 0, n_drop = 0, n_empty = 0, n_clr = 0;

    ordering_table_depth_sort_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_depth_key    (i_depth_key),
        .i_prim_kind    (i_prim_kind),
        .i_payload_tag  (i_payload_tag),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_kind     (o_out_kind),
        .o_out_tag      (o_out_tag),
        .o_out_depth    (o_out_depth),
        .o_last_of_frame(o_last_of_frame)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void empty_table();
        for (int b = 0; b < NBKT; b++) tbl_used[b] = 1'b0;
        tbl_fill      = 0;
        tbl_emitted   = 0;
        tbl_scan_bkt  = NBKT - 1;
        tbl_scan_node = NREC;
        tbl_drain     = 1'b0;
    endfunction

    // Work out the result word of one accepted word and update the table.
    function automatic t_answer sort_step(t_word w);
        t_answer a;
        int      bkt;
        int      node;
        a = '{ST_DROPPED, 2'd0, 16'd0, 12'd0, 1'b0};
        case (w.op)
            OP_INSERT: begin
                if (!tbl_drain && tbl_fill < NREC) begin
                    bkt = (w.key >= NBKT) ? NBKT - 1 : int'(w.key);
                    node = tbl_fill;
                    tbl_fill++;
                    tbl_rec[node]  = {w.kind, w.tag};
                    tbl_link[node] = tbl_used[bkt] ? int'(tbl_head[bkt]) : NREC;
                    tbl_head[bkt]  = node[11:0];
                    tbl_used[bkt]  = 1'b1;
                    a.status = ST_INSERTED;
                end
            end
            OP_FETCH: begin
                tbl_drain = 1'b1;
                a.status  = ST_EMPTY;
                if (tbl_emitted < tbl_fill) begin
                    if (tbl_scan_node >= NREC) begin
                        // priority search, farthest bucket first
                        while (tbl_scan_bkt >= 0 && !tbl_used[tbl_scan_bkt])
                            tbl_scan_bkt--;
                        if (tbl_scan_bkt >= 0)
                            tbl_scan_node = int'(tbl_head[tbl_scan_bkt]);
                    end
                    if (tbl_scan_bkt >= 0 && tbl_scan_node < NREC) begin
                        node = tbl_scan_node;
                        bkt  = tbl_scan_bkt;
                        tbl_scan_node = tbl_link[node];
                        if (tbl_scan_node >= NREC) begin
                            tbl_scan_node = NREC;
                            tbl_scan_bkt  = bkt - 1;
                        end
                        tbl_emitted++;
                        a.status = ST_EMITTED;
                        a.kind   = tbl_rec[node][17:16];
                        a.tag    = tbl_rec[node][15:0];
                        a.depth  = bkt[11:0];
                        a.last   = (tbl_emitted == tbl_fill);
                    end
                end
            end
            OP_CLEAR: begin
                empty_table();
                a.status = ST_CLEARED;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Pick a depth key: mostly far buckets so the search stays short, with
    // keys past the table and, in wide frames, anywhere in the key range.
    function automatic logic [15:0] pick_key(bit wide);
        int r;
        r = $urandom_range(99);
        if (wide && r < 30) return 16'($urandom);
        if (r < 15) return 16'($urandom_range(65535, NBKT));
        return 16'($urandom_range(NBKT - 1, NBKT - 128));
    endfunction

    function automatic void add_word(t_op op, logic [15:0] key, logic [1:0] kind,
                                     logic [15:0] tag);
        t_word w;
        w.op   = op;
        w.key  = key;
        w.kind = kind;
        w.tag  = tag;
        word_q.push_back(w);
    endfunction

    // One frame: clear, inserts, a full drain with extra fetches past the end.
    function automatic void add_frame(int n_prims, bit wide, bit noisy);
        add_word(OP_CLEAR, 16'($urandom), 2'($urandom), 16'($urandom));
        for (int k = 0; k < n_prims; k++) begin
            if (noisy && $urandom_range(9) == 0)
                add_word(OP_NONE, 16'($urandom), 2'($urandom), 16'($urandom));
            add_word(OP_INSERT, pick_key(wide), 2'($urandom), 16'($urandom));
        end
        for (int k = 0; k < n_prims + 2; k++) begin
            add_word(OP_FETCH, 16'($urandom), 2'($urandom), 16'($urandom));
            // an insert in the middle of a drain must be dropped
            if (noisy && $urandom_range(7) == 0)
                add_word(OP_INSERT, pick_key(wide), 2'($urandom), 16'($urandom));
        end
    endfunction

    // Percent of cycles the driver holds start low, by phase of the run.
    function automatic int gap_percent(int n);
        case ((n / 300) % 5)
            0: return 0;
            1: return 62;
            2: return 0;
            3: return 6;
            default: return $urandom_range(40);
        endcase
    endfunction

    // Driver: advance to the next word when the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) void'(word_q.pop_front());
            if (word_q.size() > 0 &&
                $urandom_range(99) >= gap_percent(words_taken)) begin
                start         <= 1'b1;
                i_opcode      <= word_q[0].op;
                i_depth_key   <= word_q[0].key;
                i_prim_kind   <= word_q[0].kind;
                i_payload_tag <= word_q[0].tag;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on every taken word first, then check any result word
    // in the same edge so a same-cycle answer still finds its expectation.
    always @(posedge i_clk) begin
        t_word   w;
        t_answer e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy) begin
                w.op   = t_op'(i_opcode);
                w.key  = i_depth_key;
                w.kind = i_prim_kind;
                w.tag  = i_payload_tag;
                answer_q.push_back(sort_step(w));
                words_taken++;
            end
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d", $time, o_status);
                    errors++;
                end else begin
                    e = answer_q.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                        errors++;
                    end
                    if (o_out_kind !== e.kind) begin
                        $display("%0t: kind exp %0d got %0d", $time, e.kind, o_out_kind);
                        errors++;
                    end
                    if (o_out_tag !== e.tag) begin
                        $display("%0t: tag exp %h got %h", $time, e.tag, o_out_tag);
                        errors++;
                    end
                    if (o_out_depth !== e.depth) begin
                        $display("%0t: depth exp %0d got %0d", $time, e.depth, o_out_depth);
                        errors++;
                    end
                    if (o_last_of_frame !== e.last) begin
                        $display("%0t: last exp %0d got %0d", $time, e.last,
                                 o_last_of_frame);
                        errors++;
                    end
                    case (e.status)
                        ST_INSERTED: n_ins++;
                        ST_EMITTED:  n_emit++;
                        ST_EMPTY:    n_empty++;
                        ST_CLEARED:  n_clr++;
                        default:     n_drop++;
                    endcase
                end
            end
        end
    end

    initial begin
        int frames;
        empty_table();

        // directed: empty fetch, key extremes and clamp, odd kind, unused
        // opcode, full drain, insert during drain, clear, empty again
        add_word(OP_FETCH,  16'h0000, 2'd0, 16'h0000);
        add_word(OP_CLEAR,  16'hffff, 2'd3, 16'hffff);
        add_word(OP_INSERT, 16'h0000, 2'd0, 16'h0000);
        add_word(OP_INSERT, 16'hffff, 2'd3, 16'hffff);
        add_word(OP_INSERT, 16'd4095, 2'd1, 16'h5a5a);
        add_word(OP_INSERT, 16'd4096, 2'd2, 16'ha5a5);
        add_word(OP_INSERT, 16'h0000, 2'd1, 16'h1234);
        add_word(OP_NONE,   16'hffff, 2'd3, 16'hffff);
        for (int k = 0; k < 6; k++) add_word(OP_FETCH, 16'hffff, 2'd3, 16'hffff);
        add_word(OP_INSERT, 16'd100, 2'd2, 16'hbeef);
        add_word(OP_CLEAR,  16'h0000, 2'd0, 16'h0000);
        add_word(OP_FETCH,  16'h0000, 2'd0, 16'h0000);
        add_word(OP_INSERT, 16'd7, 2'd1, 16'h0f0f);
        add_word(OP_FETCH,  16'h0000, 2'd0, 16'h0000);
        add_word(OP_FETCH,  16'h0000, 2'd0, 16'h0000);

        // random frames
        frames = 0;
        while (word_q.size() < 1950) begin
            add_frame($urandom_range(40, 1), $urandom_range(7) == 0,
                      $urandom_range(3) != 0);
            frames++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() > 0 || start || answer_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d words in %0d frames: %0d inserted, %0d emitted,",
                 words_taken, frames, n_ins, n_emit);
        $display("%0d dropped, %0d empty answers, %0d clears, %0d cycles.",
                 n_drop, n_empty, n_clr, cycles);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
